// ----- rtl/esc_pkg.sv -----
// Shared constants, types and calendar helpers for the epoch-to-date converter.
package esc_pkg;

  // Offset that makes any signed 32-bit count non-negative; a whole number of days.
  localparam logic [32:0] SecOffset    = 33'd2147558400;  // 24856 days
  // Converts day count past the offset into days since 1901-01-01.
  localparam logic [15:0] DayBias      = 16'd346;
  localparam logic [15:0] DaysPerQuad  = 16'd1461;
  localparam logic [16:0] SecsPerDay   = 17'd86400;
  localparam logic [5:0]  SecsPerMin   = 6'd60;
  localparam logic [5:0]  MinsPerHour  = 6'd60;
  // Reciprocals: 86400 = 128 * 675, 60 = 4 * 15
  localparam logic [26:0] DayRecip     = 27'd101806633;  // ceil(2^36 / 675)
  localparam logic [15:0] MinRecip     = 16'd34953;      // ceil(2^19 / 15)
  localparam logic [9:0]  HourRecip    = 10'd547;        // ceil(2^13 / 15)
  localparam logic [7:0]  BaseYear     = 8'd1;    // 1901
  localparam logic [7:0]  YearsPerQuad = 8'd4;
  localparam logic [3:0]  LastMonth    = 4'd11;   // December, counted from 0

  // Controller to datapath commands
  typedef struct packed {
    logic ld_in;
    logic day_div;
    logic tod_sub;
    logic min_div;
    logic sec_sub;
    logic min_sub;
    logic blk_step;
    logic yr_step;
    logic mon_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic blk_ge;
    logic yr_ge;
    logic mon_ge;
  } stat_t;

  // Leap rule: divisible by four (exact for 1901..2099)
  function automatic logic [8:0] days_in_year(logic [7:0] yr);
    return (yr[1:0] == 2'b00) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/esc_in_if.sv -----
// Input channel: signed epoch seconds with valid/ready handshake.
interface esc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ----- rtl/esc_out_if.sv -----
// Output channel: broken-down calendar date and time of day.
interface esc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [4:0] day_of_month;
  logic [3:0] month_number;
  logic [7:0] years_since_1900;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_number,
                  output years_since_1900, input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input day_of_month, input month_number,
                  input years_since_1900, output ready);
endinterface

// ----- rtl/esc_dpath.sv -----
// Datapath: reciprocal-multiply divisions, year/month stepping and output register.
module esc_dpath import esc_pkg::*; (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  logic signed [31:0] epoch_seconds_i,
  output stat_t              stat_o,
  output logic [5:0]         second_of_minute_o,
  output logic [5:0]         minute_of_hour_o,
  output logic [4:0]         hour_of_day_o,
  output logic [4:0]         day_of_month_o,
  output logic [3:0]         month_number_o,
  output logic [7:0]         years_since_1900_o
);

  logic [32:0] secs_q, secs_d;
  logic [15:0] dquo_q, dquo_d;
  logic [16:0] tod_q, tod_d;
  logic [10:0] mins_q, mins_d;
  logic [15:0] day_q, day_d;
  logic [7:0]  yr_q, yr_d;
  logic [3:0]  mon_q, mon_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;

  logic [51:0] day_prod;
  logic [16:0] day_secs;
  logic [29:0] min_prod;
  logic [5:0]  min_secs;
  logic [17:0] hour_prod;
  logic [5:0]  hour_mins;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  cur_mon_len;

  // Quotients by reciprocal multiplication, exact over the operand ranges:
  // days = (secs >> 7) * DayRecip >> 36, x / 60 = (x >> 2) * recip >> shift
  assign day_prod  = 52'(secs_q[32:7]) * 52'(DayRecip);
  assign min_prod  = 30'(tod_q[16:2]) * 30'(MinRecip);
  assign hour_prod = 18'(mins_q[10:2]) * 18'(HourRecip);

  // Back-multiplied quotients; the remainders are short, so low bits suffice
  assign day_secs  = {1'b0, dquo_q} * SecsPerDay;
  assign min_secs  = mins_q[5:0] * SecsPerMin;
  assign hour_mins = {1'b0, hour_q} * MinsPerHour;

  // Calendar lookups for the current year and month
  assign year_len    = days_in_year(yr_q);
  assign leap        = (year_len == 9'd366);
  assign cur_mon_len = month_len(leap, mon_q);

  assign stat_o.blk_ge = (day_q >= DaysPerQuad);
  assign stat_o.yr_ge  = (day_q >= {7'd0, year_len});
  assign stat_o.mon_ge = (mon_q < LastMonth) && (day_q >= {11'd0, cur_mon_len});

  // Next-state logic, driven by at most one command per cycle
  always_comb begin
    secs_d = secs_q;
    dquo_d = dquo_q;
    tod_d  = tod_q;
    mins_d = mins_q;
    day_d  = day_q;
    yr_d   = yr_q;
    mon_d  = mon_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    if (cmd_i.ld_in) begin
      // offset seconds so floor division becomes unsigned division
      secs_d = {epoch_seconds_i[31], epoch_seconds_i} + SecOffset;
    end
    if (cmd_i.day_div) begin
      dquo_d = day_prod[51:36];
    end
    if (cmd_i.tod_sub) begin
      // second of the day; days since 1901-01-01
      tod_d = secs_q[16:0] - day_secs;
      day_d = dquo_q + DayBias;
    end
    if (cmd_i.min_div) begin
      mins_d = min_prod[29:19];
    end
    if (cmd_i.sec_sub) begin
      sec_d  = tod_q[5:0] - min_secs;
      hour_d = hour_prod[17:13];
    end
    if (cmd_i.min_sub) begin
      min_d = mins_q[5:0] - hour_mins;
      yr_d  = BaseYear;
      mon_d = '0;
    end
    if (cmd_i.blk_step) begin
      day_d = day_q - DaysPerQuad;
      yr_d  = yr_q + YearsPerQuad;
    end
    if (cmd_i.yr_step) begin
      day_d = day_q - {7'd0, year_len};
      yr_d  = yr_q + 8'd1;
    end
    if (cmd_i.mon_step) begin
      day_d = day_q - {11'd0, cur_mon_len};
      mon_d = mon_q + 4'd1;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    secs_q <= secs_d;
    dquo_q <= dquo_d;
    tod_q  <= tod_d;
    mins_q <= mins_d;
    day_q  <= day_d;
    yr_q   <= yr_d;
    mon_q  <= mon_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
  end

  // Output register, holds the transaction until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      second_of_minute_o <= sec_q;
      minute_of_hour_o   <= min_q;
      hour_of_day_o      <= hour_q;
      day_of_month_o     <= day_q[4:0] + 5'd1;
      month_number_o     <= mon_q + 4'd1;
      years_since_1900_o <= yr_q;
    end
  end

endmodule

// ----- rtl/esc_ctrl.sv -----
// Controller: sequences the divisions, year and month steps, and output.
module esc_ctrl import esc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DAY  = 4'd1;
  localparam logic [3:0] S_TOD  = 4'd2;
  localparam logic [3:0] S_MINS = 4'd3;
  localparam logic [3:0] S_HOUR = 4'd4;
  localparam logic [3:0] S_MINR = 4'd5;
  localparam logic [3:0] S_BLK  = 4'd6;
  localparam logic [3:0] S_YEAR = 4'd7;
  localparam logic [3:0] S_MON  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // State transitions and command decode
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_DAY;
        end
      end
      S_DAY: begin
        cmd_o.day_div = 1'b1;
        state_d       = S_TOD;
      end
      S_TOD: begin
        cmd_o.tod_sub = 1'b1;
        state_d       = S_MINS;
      end
      S_MINS: begin
        cmd_o.min_div = 1'b1;
        state_d       = S_HOUR;
      end
      S_HOUR: begin
        cmd_o.sec_sub = 1'b1;
        state_d       = S_MINR;
      end
      S_MINR: begin
        cmd_o.min_sub = 1'b1;
        state_d       = S_BLK;
      end
      S_BLK: begin
        if (stat_i.blk_ge) cmd_o.blk_step = 1'b1;
        else               state_d = S_YEAR;
      end
      S_YEAR: begin
        if (stat_i.yr_ge) cmd_o.yr_step = 1'b1;
        else              state_d = S_MON;
      end
      S_MON: begin
        if (stat_i.mon_ge) cmd_o.mon_step = 1'b1;
        else               state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction starts with the day quotient
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DAY))
    else $error("accepted transaction did not start division");
  // State register only holds defined codes
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q <= S_FIN))
    else $error("controller in undefined state");
  // Output register only reloaded when free or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
`endif

endmodule

// ----- rtl/epoch_seconds_to_calendar_date.sv -----
// Top level: signed epoch seconds to second, minute, hour, day, month and year.
// Converts one transaction at a time; ready is high only while idle. An accepted
// count is offset to a non-negative value and split by reciprocal multiplication,
// one step per cycle: day quotient, time of day, minute count, second and hour,
// minute. Then the day count since 1901 is reduced in four-year blocks, single
// years and months, and the result is loaded into the output register once that
// is free. The time to valid is set mostly by the year-block loop.
// The output register lets the next transaction be accepted while a finished
// result is still waiting to be taken.
module epoch_seconds_to_calendar_date import esc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  esc_in_if.sink   in_i,
  esc_out_if.source out_o
);

  cmd_t  cmd;
  stat_t stat;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  esc_dpath u_dpath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .epoch_seconds_i    (in_i.epoch_seconds),
    .stat_o             (stat),
    .second_of_minute_o (out_o.second_of_minute),
    .minute_of_hour_o   (out_o.minute_of_hour),
    .hour_of_day_o      (out_o.hour_of_day),
    .day_of_month_o     (out_o.day_of_month),
    .month_number_o     (out_o.month_number),
    .years_since_1900_o (out_o.years_since_1900)
  );

endmodule
